[design/palm_relative_rotation_assert.svh]
// Assertion macros shared by the palm rotation RTL.
// Expects signals clk and rst_n in the scope of each use.
`ifndef PALM_RELATIVE_ROTATION_ASSERT_SVH
`define PALM_RELATIVE_ROTATION_ASSERT_SVH

// same-cycle implication
`define PRR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/palmrr_pkg.sv]
// Types and constants for the palm relative rotation block.
// No dependencies; used by every module in design/.
package palmrr_pkg;

  localparam int COMP_WIDTH = 16;
  localparam int FRAC_BITS  = 14;
  localparam int N_AXES     = 3;
  localparam int N_COMP     = 9;

  localparam logic [1:0] OP_ESTIMATE = 2'd0;
  localparam logic [1:0] OP_CAPTURE  = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;

  typedef logic signed [COMP_WIDTH-1:0] comp_t;

  typedef struct packed {
    logic [1:0] operation;
    logic       present;
    logic       quality_ok;
    comp_t      x_axis_x;
    comp_t      x_axis_y;
    comp_t      x_axis_z;
    comp_t      y_axis_x;
    comp_t      y_axis_y;
    comp_t      y_axis_z;
    comp_t      z_axis_x;
    comp_t      z_axis_y;
    comp_t      z_axis_z;
  } in_t;

  typedef struct packed {
    logic  estimate_valid;
    logic  has_ref;
    comp_t rot_r0_c0;
    comp_t rot_r0_c1;
    comp_t rot_r0_c2;
    comp_t rot_r1_c0;
    comp_t rot_r1_c1;
    comp_t rot_r1_c2;
    comp_t rot_r2_c0;
    comp_t rot_r2_c1;
    comp_t rot_r2_c2;
  } out_t;

  // per-transaction control carried down the pipe
  typedef struct packed {
    logic est_valid;
    logic has_ref;
  } ctl_t;

endpackage

[design/palm_relative_rotation.sv]
// Palm rotation relative to a captured reference: R = current * reference^T.
// Depends on palmrr_pkg, palmrr_ctrl, palmrr_lane and the assertion macros.
//
// Takes one transaction per cycle while in_stall is low, and returns one
// result per transaction: the first registered stage holds the 27
// products (nine lanes of three 16x16 multipliers), the second registered
// stage holds the summed, rounded (half up) and saturated Q1.14 elements.
// Capture and clear take effect for the very next transaction. Each stage
// advances independently, so a new transaction is taken while a finished
// result is still stalled at the output, as long as the product stage is free.
module palm_relative_rotation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  palmrr_pkg::in_t    in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output palmrr_pkg::out_t   out_data
);
  import palmrr_pkg::*;
`include "palm_relative_rotation_assert.svh"

  comp_t cur_comp [N_COMP];
  comp_t refb_comp [N_COMP];
  comp_t elem [N_COMP];
  ctl_t  ctl;
  ctl_t  s1_ctl_r;
  logic  s1_valid_r;
  logic  s1_valid_nxt;
  logic  out_valid_r;
  logic  out_valid_nxt;
  out_t  out_data_r;
  out_t  out_data_nxt;
  logic  en_out;
  logic  en_s1;
  logic  accept;

  // axis-major, same order as the ports
  assign cur_comp[0] = in_data.x_axis_x;
  assign cur_comp[1] = in_data.x_axis_y;
  assign cur_comp[2] = in_data.x_axis_z;
  assign cur_comp[3] = in_data.y_axis_x;
  assign cur_comp[4] = in_data.y_axis_y;
  assign cur_comp[5] = in_data.y_axis_z;
  assign cur_comp[6] = in_data.z_axis_x;
  assign cur_comp[7] = in_data.z_axis_y;
  assign cur_comp[8] = in_data.z_axis_z;

  assign en_out   = !out_valid_r || !out_stall;
  assign en_s1    = !s1_valid_r || en_out;
  assign in_stall = !en_s1;
  assign accept   = in_valid && en_s1;

  palmrr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .cur_comp  (cur_comp),
    .refb_comp (refb_comp),
    .ctl       (ctl)
  );

  for (genvar r = 0; r < N_AXES; r++) begin : g_row
    for (genvar c = 0; c < N_AXES; c++) begin : g_col
      comp_t cur_a [N_AXES];
      comp_t refb_a [N_AXES];
      for (genvar a = 0; a < N_AXES; a++) begin : g_axis
        assign cur_a[a]  = cur_comp[a*N_AXES + r];
        assign refb_a[a] = refb_comp[a*N_AXES + c];
      end
      palmrr_lane u_lane (
        .clk    (clk),
        .load   (accept),
        .cur_a  (cur_a),
        .refb_a (refb_a),
        .elem   (elem[r*N_AXES + c])
      );
    end
  end

  always_comb begin
    s1_valid_nxt  = en_s1 ? in_valid : s1_valid_r;
    out_valid_nxt = en_out ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl_r <= ctl;
    end
  end

  // merge: gather the lane results, zero them when there is no estimate
  always_comb begin
    out_data_nxt.estimate_valid = s1_ctl_r.est_valid;
    out_data_nxt.has_ref        = s1_ctl_r.has_ref;
    out_data_nxt.rot_r0_c0      = s1_ctl_r.est_valid ? elem[0] : '0;
    out_data_nxt.rot_r0_c1      = s1_ctl_r.est_valid ? elem[1] : '0;
    out_data_nxt.rot_r0_c2      = s1_ctl_r.est_valid ? elem[2] : '0;
    out_data_nxt.rot_r1_c0      = s1_ctl_r.est_valid ? elem[3] : '0;
    out_data_nxt.rot_r1_c1      = s1_ctl_r.est_valid ? elem[4] : '0;
    out_data_nxt.rot_r1_c2      = s1_ctl_r.est_valid ? elem[5] : '0;
    out_data_nxt.rot_r2_c0      = s1_ctl_r.est_valid ? elem[6] : '0;
    out_data_nxt.rot_r2_c1      = s1_ctl_r.est_valid ? elem[7] : '0;
    out_data_nxt.rot_r2_c2      = s1_ctl_r.est_valid ? elem[8] : '0;
  end

  always_ff @(posedge clk) begin
    if (en_out && s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PRR_ASSERT_NOW(a_est_needs_ref, out_valid_r && out_data_r.estimate_valid,
    out_data_r.has_ref, "estimate reported without a held reference")
  `PRR_ASSERT_NOW(a_zero_when_invalid, out_valid_r && !out_data_r.estimate_valid,
    out_data_r.rot_r0_c0 == '0 && out_data_r.rot_r1_c1 == '0 &&
    out_data_r.rot_r2_c2 == '0 && out_data_r.rot_r0_c2 == '0,
    "rotation not zero on an invalid estimate")
  `PRR_ASSERT_NEXT(a_s1_held, s1_valid_r && !en_out, s1_valid_r,
    "product stage dropped a transaction while output was stalled")
  `PRR_ASSERT_NOW(a_accept_when_free, !s1_valid_r, !in_stall,
    "input stalled with an empty product stage")

endmodule

[design/palmrr_lane.sv]
// One rotation element: three products registered, then sum, round, saturate.
// Depends on palmrr_pkg.
module palmrr_lane (
  input  logic              clk,
  input  logic              load,
  input  palmrr_pkg::comp_t cur_a [palmrr_pkg::N_AXES],
  input  palmrr_pkg::comp_t refb_a [palmrr_pkg::N_AXES],
  output palmrr_pkg::comp_t elem
);
  import palmrr_pkg::*;

  localparam int CW = COMP_WIDTH;
  localparam int PW = 2 * CW;
  localparam int SW = PW + 2;

  localparam logic signed [SW-1:0] RND  = {{(SW-FRAC_BITS){1'b0}}, 1'b1,
                                           {(FRAC_BITS-1){1'b0}}};
  localparam logic signed [SW-1:0] MAXV = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = ~MAXV;

  logic signed [PW-1:0] prod_r [N_AXES];
  logic signed [SW-1:0] sum_w;
  logic signed [SW-1:0] shr_w;

  always_ff @(posedge clk) begin
    if (load) begin
      for (int a = 0; a < N_AXES; a++) begin
        prod_r[a] <= PW'(cur_a[a]) * PW'(refb_a[a]);
      end
    end
  end

  // floor((sum + half) / 2^F): the three products are summed, then rounded once
  always_comb begin
    sum_w = SW'(prod_r[0]) + SW'(prod_r[1]) + SW'(prod_r[2]) + RND;
    shr_w = sum_w >>> FRAC_BITS;
    if (shr_w > MAXV) begin
      elem = MAXV[CW-1:0];
    end else if (shr_w < MINV) begin
      elem = MINV[CW-1:0];
    end else begin
      elem = shr_w[CW-1:0];
    end
  end

endmodule

[design/palmrr_ctrl.sv]
// Operation decode and reference store (held flag plus nine axis components).
// Depends on palmrr_pkg.
module palmrr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  palmrr_pkg::in_t   in_data,
  input  palmrr_pkg::comp_t cur_comp [palmrr_pkg::N_COMP],
  output palmrr_pkg::comp_t refb_comp [palmrr_pkg::N_COMP],
  output palmrr_pkg::ctl_t  ctl
);
  import palmrr_pkg::*;

  comp_t refb_r [N_COMP];
  comp_t refb_nxt [N_COMP];
  logic  held_r;
  logic  held_nxt;
  logic  ok;

  assign ok = in_data.present & in_data.quality_ok;

  always_comb begin
    held_nxt = held_r;
    for (int i = 0; i < N_COMP; i++) begin
      refb_nxt[i] = refb_r[i];
    end
    case (in_data.operation)
      OP_CAPTURE: begin
        held_nxt = ok;
        for (int i = 0; i < N_COMP; i++) begin
          refb_nxt[i] = ok ? cur_comp[i] : '0;
        end
      end
      OP_CLEAR: begin
        held_nxt = 1'b0;
        for (int i = 0; i < N_COMP; i++) begin
          refb_nxt[i] = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
      for (int i = 0; i < N_COMP; i++) begin
        refb_r[i] <= '0;
      end
    end else if (accept) begin
      held_r <= held_nxt;
      for (int i = 0; i < N_COMP; i++) begin
        refb_r[i] <= refb_nxt[i];
      end
    end
  end

  // products use the reference as held before this transaction
  always_comb begin
    for (int i = 0; i < N_COMP; i++) begin
      refb_comp[i] = refb_r[i];
    end
  end

  assign ctl.est_valid = (in_data.operation == OP_ESTIMATE) & held_r & ok;
  assign ctl.has_ref   = held_nxt;

endmodule
